// File: sv/mau_pkg.sv
// modular arithmetic unit package: payload structs, opcodes, controller states
// no dependencies
`timescale 1ns / 1ps
package mau_pkg;

  localparam int unsigned ModBits = 62;
  localparam int unsigned OpBits  = 64;
  localparam int unsigned ExpBits = 63;

  typedef enum logic [2:0] {
    OP_REDUCE = 3'd0,
    OP_ADD    = 3'd1,
    OP_SUB    = 3'd2,
    OP_MUL    = 3'd3,
    OP_DIV    = 3'd4,
    OP_POW    = 3'd5,
    OP_NEG    = 3'd6,
    OP_NONE   = 3'd7
  } mode_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic [OpBits-1:0]  operand_a;
    logic [ModBits-1:0] operand_b;
    logic [ExpBits-1:0] exponent;
  } in_item_t;

  typedef struct packed {
    logic [ModBits-1:0] result;
    logic               no_inverse;
  } out_item_t;

  // datapath micro-operations
  typedef enum logic [3:0] {
    DP_IDLE,
    DP_LOAD,      // latch operands, start reduction of a
    DP_RED_A,     // one bit of restoring reduction of |a|
    DP_FIX_A,     // negate residue for negative a
    DP_RED_B,     // one bit of reduction of b
    DP_MUL_INIT,  // start shift-add multiply of mx * my
    DP_MUL_STEP,  // one bit of multiply
    DP_DIV_STEP,  // one bit of long division y / x
    DP_EUC_UPD,   // euclid update after quotient and t*cx known
    DP_FINAL      // form output
  } dp_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RED_A,
    S_FIX_A,
    S_RED_B,
    S_DISPATCH,
    S_EUC_DIV,
    S_EUC_MUL,
    S_EUC_UPD,
    S_MUL,
    S_POW_NEXT,
    S_FINAL,
    S_OUT
  } state_t;

  // multiply operand selection
  typedef enum logic [2:0] {
    MS_A_B,    // a * b
    MS_A_INV,  // a * cy
    MS_RES_BASE,
    MS_BASE_BASE,
    MS_T_CX
  } msel_t;

  typedef struct packed {
    dp_cmd_t cmd;
    msel_t   msel;
    logic    mul_to_res;  // where the product goes
    logic    mul_to_base;
  } dp_ctrl_t;

  typedef struct packed {
    logic       count_done;
    logic       a_neg;
    logic       x_zero;
    logic       exp_bit;
    logic       exp_last;
    logic [2:0] mode;
  } dp_stat_t;

endpackage

// File: sv/mau_datapath.sv
// modular arithmetic datapath: bit-serial reduce, multiply, division and euclid registers
// depends on mau_pkg
`timescale 1ns / 1ps
module mau_datapath #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [61:0]         cfg_data,
  input  mau_pkg::in_item_t   in_item,
  input  mau_pkg::dp_ctrl_t   ctrl,
  output mau_pkg::dp_stat_t   stat,
  output mau_pkg::out_item_t  out_item
);
  import mau_pkg::*;

  localparam int unsigned CntBits = 7;

  logic [ModBits-1:0] modulus;
  logic [ModBits-1:0] m;
  logic [2:0]         mode;
  logic [OpBits-1:0]  mag;      // shifting magnitude for reductions
  logic               a_neg;
  logic [ModBits-1:0] a, b, res, base, acc;
  logic [ModBits-1:0] mx, my;   // multiply operands
  logic [ExpBits-1:0] e;
  logic [CntBits-1:0] cnt;
  // euclid
  logic [ModBits-1:0] x, y, q, cx, cy, rem;
  logic [ModBits-1:0] tcx;

  assign m = (modulus == '0) ? ModBits'(1) : modulus;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= ModBits'(1);
    end else if (cfg_we) begin
      modulus <= cfg_data;
    end
  end

  // shared add/double modulo m
  function automatic logic [ModBits-1:0] addm(input logic [ModBits-1:0] p,
                                              input logic [ModBits-1:0] r,
                                              input logic [ModBits-1:0] mm);
    logic [ModBits:0] s;
    s = {1'b0, p} + {1'b0, r};
    return (s >= {1'b0, mm}) ? ModBits'(s - {1'b0, mm}) : s[ModBits-1:0];
  endfunction

  logic [ModBits:0]   red_sh;
  logic [ModBits-1:0] mul_dbl, mul_nxt;
  logic [ModBits:0]   div_sh;
  logic [WORD_BITS-1:0] a_raw;
  logic               a_sign;

  assign a_raw  = in_item.operand_a[WORD_BITS-1:0];
  assign a_sign = a_raw[WORD_BITS-1];
  assign red_sh = {acc, mag[OpBits-1]};
  assign mul_dbl = addm(acc, acc, m);
  assign mul_nxt = my[ModBits-1] ? addm(mul_dbl, mx, m) : mul_dbl;
  assign div_sh  = {rem, q[ModBits-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      case (ctrl.cmd)
        DP_LOAD: begin
          mode  <= in_item.mode;
          a_neg <= a_sign;
          mag   <= OpBits'(a_sign ? (~a_raw + 1'b1) : a_raw) << (OpBits - WORD_BITS);
          b     <= in_item.operand_b;
          e     <= in_item.exponent;
          acc   <= '0;
          cnt   <= CntBits'(WORD_BITS - 1);
        end
        DP_RED_A, DP_RED_B: begin
          acc <= (red_sh >= {1'b0, m}) ? ModBits'(red_sh - {1'b0, m}) : red_sh[ModBits-1:0];
          mag <= mag << 1;
          // last bit rearms the counter for the first euclid division
          cnt <= (cnt == '0) ? CntBits'(ModBits - 1) : cnt - 1'b1;
        end
        DP_FIX_A: begin
          a   <= (a_neg && acc != '0) ? m - acc : acc;
          acc <= '0;
          mag <= {b, 2'b00};
          cnt <= CntBits'(ModBits - 1);
        end
        DP_MUL_INIT: begin
          acc <= '0;
          cnt <= CntBits'(ModBits - 1);
          case (ctrl.msel)
            MS_A_B:       begin mx <= a;    my <= b;  end
            MS_A_INV:     begin mx <= a;    my <= cy; end
            MS_RES_BASE:  begin mx <= base; my <= res; end
            MS_BASE_BASE: begin mx <= base; my <= base; end
            default:      begin mx <= cx;   my <= q;  end
          endcase
        end
        DP_MUL_STEP: begin
          acc <= mul_nxt;
          my  <= my << 1;
          cnt <= cnt - 1'b1;
        end
        DP_DIV_STEP: begin
          // restoring division of y by x; q shifts in quotient bits
          if (div_sh >= {1'b0, x}) begin
            rem <= ModBits'(div_sh - {1'b0, x});
            q   <= {q[ModBits-2:0], 1'b1};
          end else begin
            rem <= div_sh[ModBits-1:0];
            q   <= {q[ModBits-2:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
        end
        DP_EUC_UPD: begin
          y  <= x;
          x  <= rem;
          cy <= cx;
          cx <= (cy >= tcx) ? cy - tcx : cy + (m - tcx);
          q  <= x;  // dividend for next step is new y
          rem <= '0;
          cnt <= CntBits'(ModBits - 1);
        end
        DP_FINAL: begin
          acc <= acc;
        end
        default: ;
      endcase
      // multiply result routing and setup of euclid / power
      if (ctrl.cmd == DP_RED_B && cnt == '0) begin
        // b reduced, set up euclid and power registers
        x    <= (red_sh >= {1'b0, m}) ? ModBits'(red_sh - {1'b0, m}) : red_sh[ModBits-1:0];
        y    <= m;
        q    <= m;
        rem  <= '0;
        cx   <= (m == ModBits'(1)) ? '0 : ModBits'(1);
        cy   <= '0;
        res  <= (m == ModBits'(1)) ? '0 : ModBits'(1);
        base <= a;
        b    <= (red_sh >= {1'b0, m}) ? ModBits'(red_sh - {1'b0, m}) : red_sh[ModBits-1:0];
      end
      if (ctrl.cmd == DP_FIX_A) begin
        base <= (a_neg && acc != '0) ? m - acc : acc;
      end
      if (ctrl.cmd == DP_MUL_STEP && cnt == '0) begin
        if (ctrl.mul_to_res)  res  <= mul_nxt;
        if (ctrl.mul_to_base) base <= mul_nxt;
        if (ctrl.msel == MS_T_CX) tcx <= mul_nxt;
      end
      if (ctrl.cmd == DP_EUC_UPD || (ctrl.cmd == DP_MUL_STEP && ctrl.msel == MS_RES_BASE)) begin
        // nothing extra
      end
      if (ctrl.cmd == DP_FINAL) begin
        e <= e;
      end
      if (ctrl.cmd == DP_MUL_INIT && ctrl.msel == MS_BASE_BASE) begin
        e <= e >> 1;
      end
    end
  end

  // output formation
  always_comb begin
    out_item.no_inverse = 1'b0;
    out_item.result     = '0;
    case (mode_t'(mode))
      OP_REDUCE: out_item.result = a;
      OP_ADD:    out_item.result = addm(a, b, m);
      OP_SUB:    out_item.result = (a >= b) ? a - b : a + (m - b);
      OP_MUL:    out_item.result = res;
      OP_DIV: begin
        if (y == ModBits'(1)) out_item.result = res;
        else out_item.no_inverse = 1'b1;
      end
      OP_POW:    out_item.result = res;
      OP_NEG:    out_item.result = (a == '0) ? '0 : m - a;
      default:   ;
    endcase
  end

  assign stat.count_done = (cnt == '0);
  assign stat.a_neg      = a_neg;
  assign stat.x_zero     = (x == '0);
  assign stat.exp_bit    = e[0];
  // exponent bits left after the squaring that already shifted e
  assign stat.exp_last   = (e == '0);
  assign stat.mode       = mode;
endmodule

// File: sv/mau_ctrl.sv
// modular arithmetic controller: sequences reductions, multiplies, euclid and power loop
// depends on mau_pkg
`timescale 1ns / 1ps
module mau_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  mau_pkg::dp_stat_t  stat,
  output mau_pkg::dp_ctrl_t  ctrl
);
  import mau_pkg::*;

  state_t state, state_next;
  msel_t  msel, msel_next;   // multiply in flight
  logic   to_res, to_base, to_res_next, to_base_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      msel    <= MS_A_B;
      to_res  <= 1'b0;
      to_base <= 1'b0;
    end else begin
      state   <= state_next;
      msel    <= msel_next;
      to_res  <= to_res_next;
      to_base <= to_base_next;
    end
  end

  always_comb begin
    state_next   = state;
    msel_next    = msel;
    to_res_next  = to_res;
    to_base_next = to_base;
    ctrl.cmd     = DP_IDLE;
    ctrl.msel    = msel;
    ctrl.mul_to_res  = to_res;
    ctrl.mul_to_base = to_base;
    in_stall     = 1'b1;
    out_valid    = 1'b0;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctrl.cmd   = DP_LOAD;
          state_next = S_RED_A;
        end
      end
      S_RED_A: begin
        ctrl.cmd = DP_RED_A;
        if (stat.count_done) state_next = S_FIX_A;
      end
      S_FIX_A: begin
        ctrl.cmd   = DP_FIX_A;
        state_next = S_RED_B;
      end
      S_RED_B: begin
        ctrl.cmd = DP_RED_B;
        if (stat.count_done) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (mode_t'(stat.mode))
          OP_MUL: begin
            ctrl.cmd = DP_MUL_INIT; ctrl.msel = MS_A_B;
            msel_next = MS_A_B; to_res_next = 1'b1; to_base_next = 1'b0;
            state_next = S_MUL;
          end
          OP_DIV: begin
            if (stat.x_zero) begin
              state_next = S_FINAL;
            end else begin
              state_next = S_EUC_DIV;
            end
          end
          OP_POW: begin
            if (stat.exp_bit) begin
              ctrl.cmd = DP_MUL_INIT; ctrl.msel = MS_RES_BASE;
              msel_next = MS_RES_BASE; to_res_next = 1'b1; to_base_next = 1'b0;
            end else begin
              ctrl.cmd = DP_MUL_INIT; ctrl.msel = MS_BASE_BASE;
              msel_next = MS_BASE_BASE; to_res_next = 1'b0; to_base_next = 1'b1;
            end
            state_next = S_MUL;
          end
          default: state_next = S_FINAL;
        endcase
      end
      S_EUC_DIV: begin
        ctrl.cmd = DP_DIV_STEP;
        if (stat.count_done) begin
          state_next = S_EUC_MUL;
        end
      end
      S_EUC_MUL: begin
        ctrl.cmd = DP_MUL_INIT; ctrl.msel = MS_T_CX;
        msel_next = MS_T_CX; to_res_next = 1'b0; to_base_next = 1'b0;
        state_next = S_MUL;
      end
      S_EUC_UPD: begin
        ctrl.cmd   = DP_EUC_UPD;
        state_next = S_DISPATCH;
      end
      S_MUL: begin
        ctrl.cmd = DP_MUL_STEP;
        if (stat.count_done) begin
          case (msel)
            MS_T_CX:     state_next = S_EUC_UPD;
            MS_RES_BASE: state_next = S_POW_NEXT;
            MS_BASE_BASE: state_next = S_POW_NEXT;
            default:     state_next = S_FINAL;
          endcase
        end
      end
      S_POW_NEXT: begin
        if (msel == MS_RES_BASE) begin
          ctrl.cmd = DP_MUL_INIT; ctrl.msel = MS_BASE_BASE;
          msel_next = MS_BASE_BASE; to_res_next = 1'b0; to_base_next = 1'b1;
          state_next = S_MUL;
        end else if (stat.exp_last) begin
          state_next = S_FINAL;
        end else if (stat.exp_bit) begin
          ctrl.cmd = DP_MUL_INIT; ctrl.msel = MS_RES_BASE;
          msel_next = MS_RES_BASE; to_res_next = 1'b1; to_base_next = 1'b0;
          state_next = S_MUL;
        end else begin
          ctrl.cmd = DP_MUL_INIT; ctrl.msel = MS_BASE_BASE;
          msel_next = MS_BASE_BASE; to_res_next = 1'b0; to_base_next = 1'b1;
          state_next = S_MUL;
        end
      end
      S_FINAL: begin
        // divide ends with a times the inverse found by euclid
        if (stat.mode == OP_DIV && msel != MS_A_INV) begin
          ctrl.cmd = DP_MUL_INIT; ctrl.msel = MS_A_INV;
          msel_next = MS_A_INV; to_res_next = 1'b1; to_base_next = 1'b0;
          state_next = S_MUL;
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = S_IDLE;
          msel_next  = MS_A_B;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// File: sv/modular_arithmetic_unit_core.sv
// modular arithmetic unit, one item at a time
// add/sub/neg/reduce need only the operand reductions, multiply adds a bit-serial multiply,
// divide runs euclid steps (a long division and a multiply each) and then a multiply,
// and power a square-and-multiply loop; a new item is taken only once the result is delivered
// rst (synchronous, active high) returns the controller to idle and modulus to 1
`timescale 1ns / 1ps
module modular_arithmetic_unit_core #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [61:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  mau_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output mau_pkg::out_item_t out_item
);
  import mau_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  // controller sequences each transaction through the shared datapath
  mau_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .ctrl
  );

  mau_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk, .rst, .cfg_we, .cfg_data, .in_item, .ctrl, .stat, .out_item
  );
endmodule

// File: sv/mau_checker.sv
// port-level checker for the modular arithmetic unit, bound to the top level
// depends on mau_pkg
`timescale 1ns / 1ps
module mau_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input mau_pkg::out_item_t out_item
);
  import mau_pkg::*;

  // single item in flight: no acceptance while a result is shown
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while result pending");
  // result delivered means ready for next item
  a_ret: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> !out_valid) else $error("result repeated");
  // accepted input yields no result next cycle
  a_lat: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !out_valid) else $error("result too early");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(out_item)) else $error("payload moved");
endmodule

bind modular_arithmetic_unit_core mau_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .out_item
);
